// ===== rtl/i2c_byte_master_defines.svh =====
// ---------------------------------------------------------------------------
// I2C byte master assertion macros
// Shared property forms for the port checker.
// ---------------------------------------------------------------------------
`ifndef I2C_BYTE_MASTER_DEFINES_SVH
`define I2C_BYTE_MASTER_DEFINES_SVH

// same-cycle implication, sampled on clock, off while reset is high
`define I2CBM_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, sampled on clock, off while reset is high
`define I2CBM_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/i2cbm_pkg.sv =====
// ---------------------------------------------------------------------------
// I2C byte master package
// Word types, command, phase and status codes shared by the block.
// ---------------------------------------------------------------------------
package i2cbm_pkg;

   typedef struct packed {
      logic [2:0] action;
      logic [7:0] tx_byte;
      logic       send_nack;
      logic       msb_first;
      logic       sda_line;
   } req_word_type;

   typedef struct packed {
      logic       scl_drive;
      logic       sda_drive;
      logic       busy_res;
      logic       done_res;
      logic [1:0] status;
      logic [7:0] rx_byte;
      logic       rejected;
   } rsp_word_type;

   // commands
   localparam logic [2:0] ACT_TICK  = 3'd0;
   localparam logic [2:0] ACT_START = 3'd1;
   localparam logic [2:0] ACT_STOP  = 3'd2;
   localparam logic [2:0] ACT_WRITE = 3'd3;
   localparam logic [2:0] ACT_READ  = 3'd4;

   // sequencer phases
   localparam logic [3:0] PH_IDLE      = 4'd0;
   localparam logic [3:0] PH_START_A   = 4'd1;
   localparam logic [3:0] PH_START_B   = 4'd2;
   localparam logic [3:0] PH_START_C   = 4'd3;
   localparam logic [3:0] PH_STOP_A    = 4'd4;
   localparam logic [3:0] PH_STOP_B    = 4'd5;
   localparam logic [3:0] PH_STOP_C    = 4'd6;
   localparam logic [3:0] PH_W_SETUP   = 4'd7;
   localparam logic [3:0] PH_W_HIGH    = 4'd8;
   localparam logic [3:0] PH_W_ACKWAIT = 4'd9;
   localparam logic [3:0] PH_W_ACKHIGH = 4'd10;
   localparam logic [3:0] PH_R_HIGH    = 4'd11;
   localparam logic [3:0] PH_R_LOW     = 4'd12;
   localparam logic [3:0] PH_R_ACKHIGH = 4'd13;
   localparam logic [3:0] PH_R_ACKLOW  = 4'd14;

   // status codes
   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_NACK    = 2'd1;
   localparam logic [1:0] ST_BUS_ERR = 2'd2;
   localparam logic [1:0] ST_RSVD    = 2'd3;

   localparam logic [3:0] BYTE_BITS        = 4'd8;
   localparam logic [7:0] HALF_PERIOD_INIT = 8'd5;

endpackage

// ===== rtl/i2cbm_seq.sv =====
// ---------------------------------------------------------------------------
// I2C byte master sequencer
// Bus state stepped per half period of ticks, result word built alongside.
// ---------------------------------------------------------------------------
module i2cbm_seq (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step,
   input  i2cbm_pkg::req_word_type item,
   input  logic [7:0]             half_period,
   output i2cbm_pkg::rsp_word_type result
);

   logic [3:0] phase_ff, phase_in;
   logic [3:0] bit_count_ff, bit_count_in;
   logic [7:0] shift_ff, shift_in;
   logic [7:0] tick_count_ff, tick_count_in;
   logic       scl_ff, scl_in;
   logic       sda_ff, sda_in;
   logic [1:0] status_ff, status_in;
   logic [1:0] read_opt_ff, read_opt_in;
   logic [7:0] rx_hold_ff, rx_hold_in;

   logic       busy;
   logic       done;
   logic       rej;
   logic [7:0] limit;
   logic [7:0] tick_inc;
   logic [3:0] bc_inc;
   logic [7:0] shift_left;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= i2cbm_pkg::PH_IDLE;
         bit_count_ff  <= 4'd0;
         shift_ff      <= 8'd0;
         tick_count_ff <= 8'd0;
         scl_ff        <= 1'b1;
         sda_ff        <= 1'b1;
         status_ff     <= i2cbm_pkg::ST_OK;
         read_opt_ff   <= 2'd0;
         rx_hold_ff    <= 8'd0;
      end else if (step) begin
         phase_ff      <= phase_in;
         bit_count_ff  <= bit_count_in;
         shift_ff      <= shift_in;
         tick_count_ff <= tick_count_in;
         scl_ff        <= scl_in;
         sda_ff        <= sda_in;
         status_ff     <= status_in;
         read_opt_ff   <= read_opt_in;
         rx_hold_ff    <= rx_hold_in;
      end
   end

   assign busy       = (phase_ff != i2cbm_pkg::PH_IDLE);
   assign limit      = (half_period == 8'd0) ? 8'd1 : half_period;
   assign tick_inc   = tick_count_ff + 8'd1;
   assign bc_inc     = bit_count_ff + 4'd1;
   assign shift_left = {shift_ff[6:0], 1'b0};

   always_comb begin
      phase_in      = phase_ff;
      bit_count_in  = bit_count_ff;
      shift_in      = shift_ff;
      tick_count_in = tick_count_ff;
      scl_in        = scl_ff;
      sda_in        = sda_ff;
      status_in     = status_ff;
      read_opt_in   = read_opt_ff;
      rx_hold_in    = rx_hold_ff;
      done          = 1'b0;
      rej           = 1'b0;

      unique case (item.action) inside
         i2cbm_pkg::ACT_TICK: begin
            if (busy) begin
               tick_count_in = tick_inc;
               if (tick_inc >= limit) begin
                  tick_count_in = 8'd0;
                  unique case (phase_ff) inside
                     i2cbm_pkg::PH_START_A: begin
                        sda_in   = 1'b0;
                        phase_in = i2cbm_pkg::PH_START_B;
                     end
                     i2cbm_pkg::PH_START_B: begin
                        scl_in   = 1'b0;
                        phase_in = i2cbm_pkg::PH_START_C;
                     end
                     i2cbm_pkg::PH_START_C,
                     i2cbm_pkg::PH_STOP_C: begin
                        status_in = (item.sda_line == scl_ff) ? i2cbm_pkg::ST_OK
                                                              : i2cbm_pkg::ST_BUS_ERR;
                        done      = 1'b1;
                     end
                     i2cbm_pkg::PH_STOP_A: begin
                        scl_in   = 1'b1;
                        phase_in = i2cbm_pkg::PH_STOP_B;
                     end
                     i2cbm_pkg::PH_STOP_B: begin
                        sda_in   = 1'b1;
                        phase_in = i2cbm_pkg::PH_STOP_C;
                     end
                     i2cbm_pkg::PH_W_SETUP: begin
                        scl_in   = 1'b1;
                        phase_in = i2cbm_pkg::PH_W_HIGH;
                     end
                     i2cbm_pkg::PH_W_HIGH: begin
                        scl_in       = 1'b0;
                        shift_in     = shift_left;
                        bit_count_in = bc_inc;
                        if (bc_inc < i2cbm_pkg::BYTE_BITS) begin
                           sda_in   = shift_left[7];
                           phase_in = i2cbm_pkg::PH_W_SETUP;
                        end else begin
                           sda_in   = 1'b1;
                           phase_in = i2cbm_pkg::PH_W_ACKWAIT;
                        end
                     end
                     i2cbm_pkg::PH_W_ACKWAIT: begin
                        status_in = item.sda_line ? i2cbm_pkg::ST_NACK : i2cbm_pkg::ST_OK;
                        scl_in    = 1'b1;
                        phase_in  = i2cbm_pkg::PH_W_ACKHIGH;
                     end
                     i2cbm_pkg::PH_W_ACKHIGH: begin
                        scl_in = 1'b0;
                        done   = 1'b1;
                     end
                     i2cbm_pkg::PH_R_HIGH: begin
                        if (read_opt_ff[1]) begin
                           shift_in = {shift_ff[6:0], item.sda_line};
                        end else begin
                           shift_in = {item.sda_line, shift_ff[7:1]};
                        end
                        scl_in       = 1'b0;
                        bit_count_in = bc_inc;
                        if (bc_inc >= i2cbm_pkg::BYTE_BITS) begin
                           sda_in = read_opt_ff[0];
                        end
                        phase_in = i2cbm_pkg::PH_R_LOW;
                     end
                     i2cbm_pkg::PH_R_LOW: begin
                        scl_in   = 1'b1;
                        phase_in = (bit_count_ff < i2cbm_pkg::BYTE_BITS)
                                   ? i2cbm_pkg::PH_R_HIGH : i2cbm_pkg::PH_R_ACKHIGH;
                     end
                     i2cbm_pkg::PH_R_ACKHIGH: begin
                        scl_in   = 1'b0;
                        phase_in = i2cbm_pkg::PH_R_ACKLOW;
                     end
                     i2cbm_pkg::PH_R_ACKLOW: begin
                        sda_in     = 1'b1;
                        rx_hold_in = shift_ff;
                        done       = 1'b1;
                     end
                     default: begin
                        done = 1'b1;
                     end
                  endcase
                  if (done) begin
                     phase_in = i2cbm_pkg::PH_IDLE;
                  end
               end
            end
         end
         i2cbm_pkg::ACT_START, i2cbm_pkg::ACT_STOP,
         i2cbm_pkg::ACT_WRITE, i2cbm_pkg::ACT_READ: begin
            if (busy) begin
               rej = 1'b1;
            end else begin
               tick_count_in = 8'd0;
               bit_count_in  = 4'd0;
               unique case (item.action)
                  i2cbm_pkg::ACT_START: begin
                     scl_in   = 1'b1;
                     sda_in   = 1'b1;
                     phase_in = i2cbm_pkg::PH_START_A;
                  end
                  i2cbm_pkg::ACT_STOP: begin
                     sda_in   = 1'b0;
                     phase_in = i2cbm_pkg::PH_STOP_A;
                  end
                  i2cbm_pkg::ACT_WRITE: begin
                     shift_in = item.tx_byte;
                     sda_in   = item.tx_byte[7];
                     phase_in = i2cbm_pkg::PH_W_SETUP;
                  end
                  default: begin
                     read_opt_in = {item.msb_first, item.send_nack};
                     shift_in    = 8'd0;
                     sda_in      = 1'b1;
                     scl_in      = 1'b1;
                     phase_in    = i2cbm_pkg::PH_R_HIGH;
                  end
               endcase
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      result.scl_drive = scl_in;
      result.sda_drive = sda_in;
      result.busy_res  = (phase_in != i2cbm_pkg::PH_IDLE);
      result.done_res  = done;
      result.status    = status_in;
      result.rx_byte   = rx_hold_in;
      result.rejected  = rej;
   end

endmodule

// ===== rtl/i2cbm_out.sv =====
// ---------------------------------------------------------------------------
// I2C byte master result stage
// Result register with valid/stall handshake toward the consumer.
// ---------------------------------------------------------------------------
module i2cbm_out (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    load,
   input  i2cbm_pkg::rsp_word_type word,
   output logic                    free,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output i2cbm_pkg::rsp_word_type rsp_word
);

   logic                    valid_ff, valid_in;
   i2cbm_pkg::rsp_word_type word_ff;

   assign free = !valid_ff || !rsp_stall;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         word_ff <= word;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_word  = word_ff;

endmodule

// ===== rtl/i2c_byte_master.sv =====
// ---------------------------------------------------------------------------
// I2C byte master
// Byte-level open-drain I2C master: start, stop, write and read sequences
// paced by tick words that carry the sampled SDA level.
// ---------------------------------------------------------------------------
//  port group   direction   handshake          payload
//  req_*        in          valid / stall      req_word_type
//  rsp_*        out         valid / stall      rsp_word_type
//  csr_*        in          valid / ready      half_period_ticks, 8 bits
//
//  One word per cycle sustained while rsp_* is not stalled; a result word
//  passes the input register, then the result register, before rsp_*.
//  The sequencer's next-state logic between the two registers is combinational.
//  Synchronous active-high reset: idle, lines released, half period 5.
//  A stalled result holds the request register; req_stall then rises.
// ---------------------------------------------------------------------------
module i2c_byte_master (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  i2cbm_pkg::req_word_type req_word,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output i2cbm_pkg::rsp_word_type rsp_word,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [7:0]              csr_wdata
);

   logic                    req_valid_ff, req_valid_in;
   i2cbm_pkg::req_word_type req_word_ff;
   logic [7:0]              half_period_ff;
   logic                    out_free;
   logic                    step;
   logic                    take;
   i2cbm_pkg::rsp_word_type result;

   assign step      = req_valid_ff && out_free;
   assign req_stall = req_valid_ff && !out_free;
   assign take      = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   always_comb begin
      req_valid_in = req_valid_ff;
      if (take) begin
         req_valid_in = 1'b1;
      end else if (step) begin
         req_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff   <= 1'b0;
         half_period_ff <= i2cbm_pkg::HALF_PERIOD_INIT;
      end else begin
         req_valid_ff <= req_valid_in;
         if (csr_valid && csr_ready) begin
            half_period_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         req_word_ff <= req_word;
      end
   end

   i2cbm_seq u_seq (
      .clock       (clock),
      .reset       (reset),
      .step        (step),
      .item        (req_word_ff),
      .half_period (half_period_ff),
      .result      (result)
   );

   i2cbm_out u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (step),
      .word      (result),
      .free      (out_free),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

endmodule

// ===== rtl/i2cbm_chk.sv =====
// ---------------------------------------------------------------------------
// I2C byte master port checker
// Port-level properties of the result channel, bound to the top level.
// ---------------------------------------------------------------------------
`include "i2c_byte_master_defines.svh"

module i2cbm_chk (
   input logic                    clock,
   input logic                    reset,
   input logic                    rsp_valid,
   input logic                    rsp_stall,
   input i2cbm_pkg::rsp_word_type rsp_word
);

   `I2CBM_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_word), "stalled result word changed")
   `I2CBM_ASSERT_NOW(a_done_idle, rsp_valid && rsp_word.done_res, !rsp_word.busy_res, "done while still busy")
   `I2CBM_ASSERT_NOW(a_rej_busy, rsp_valid && rsp_word.rejected, rsp_word.busy_res && !rsp_word.done_res, "reject outside a running sequence")
   `I2CBM_ASSERT_NOW(a_status_code, rsp_valid, rsp_word.status != i2cbm_pkg::ST_RSVD, "reserved status code")

endmodule

bind i2c_byte_master i2cbm_chk u_chk (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_word  (rsp_word)
);

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// I2C byte master testbench
// Drives tick and command words against a cycle-level bus model kept here,
// checks every result word field by field, with random result stalls, random
// request gaps and several half-period settings.
// ---------------------------------------------------------------------------
module tb_top;
   import i2cbm_pkg::*;

   typedef enum {LINE_LOW, LINE_HIGH, LINE_RANDOM, LINE_PROPER} line_mode_type;

   localparam logic [2:0] ACT_SPARE_LO    = 3'd5;
   localparam logic [2:0] ACT_SPARE_HI    = 3'd7;
   localparam int         WATCHDOG_CYCLES = 2000;

   logic         clock     = 1'b0;
   logic         reset     = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_word_type req_word  = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_word_type rsp_word;
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic [7:0]   csr_wdata = 8'd0;

   // bus model state
   logic [7:0] half_ticks = HALF_PERIOD_INIT;
   logic [3:0] seq_phase  = PH_IDLE;
   logic [3:0] bit_cnt    = '0;
   logic [7:0] shifter    = '0;
   logic [7:0] tick_cnt   = '0;
   logic       scl_lvl    = 1'b1;
   logic       sda_lvl    = 1'b1;
   logic [1:0] bus_status = ST_OK;
   logic [1:0] rd_opts    = '0;
   logic [7:0] rx_held    = '0;

   rsp_word_type expected_reports[$];
   rsp_word_type want_rsp;
   int           mismatch_count = 0;
   int           live_words     = 0;
   int           quiet_cycles   = 0;
   int           stall_left     = 0;
   bit           idle_on        = 1'b0;

   always #1 clock = ~clock;

   i2c_byte_master i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_wdata (csr_wdata)
   );

   // one half-period step; returns 1 when the sequence ends
   function automatic bit bus_half_step(logic line);
      case (seq_phase) inside
         PH_START_A: begin
            sda_lvl = 1'b0;
            seq_phase = PH_START_B;
            return 1'b0;
         end
         PH_START_B: begin
            scl_lvl = 1'b0;
            seq_phase = PH_START_C;
            return 1'b0;
         end
         PH_START_C, PH_STOP_C: begin
            bus_status = (line == scl_lvl) ? ST_OK : ST_BUS_ERR;
            return 1'b1;
         end
         PH_STOP_A: begin
            scl_lvl = 1'b1;
            seq_phase = PH_STOP_B;
            return 1'b0;
         end
         PH_STOP_B: begin
            sda_lvl = 1'b1;
            seq_phase = PH_STOP_C;
            return 1'b0;
         end
         PH_W_SETUP: begin
            scl_lvl = 1'b1;
            seq_phase = PH_W_HIGH;
            return 1'b0;
         end
         PH_W_HIGH: begin
            scl_lvl = 1'b0;
            shifter = shifter << 1;
            bit_cnt = bit_cnt + 4'd1;
            if (bit_cnt < BYTE_BITS) begin
               sda_lvl = shifter[7];
               seq_phase = PH_W_SETUP;
            end else begin
               sda_lvl = 1'b1;
               seq_phase = PH_W_ACKWAIT;
            end
            return 1'b0;
         end
         PH_W_ACKWAIT: begin
            bus_status = line ? ST_NACK : ST_OK;
            scl_lvl = 1'b1;
            seq_phase = PH_W_ACKHIGH;
            return 1'b0;
         end
         PH_W_ACKHIGH: begin
            scl_lvl = 1'b0;
            return 1'b1;
         end
         PH_R_HIGH: begin
            if (rd_opts[1]) begin
               shifter = {shifter[6:0], line};
            end else begin
               shifter = {line, shifter[7:1]};
            end
            scl_lvl = 1'b0;
            bit_cnt = bit_cnt + 4'd1;
            if (bit_cnt >= BYTE_BITS) begin
               sda_lvl = rd_opts[0];
            end
            seq_phase = PH_R_LOW;
            return 1'b0;
         end
         PH_R_LOW: begin
            scl_lvl = 1'b1;
            seq_phase = (bit_cnt < BYTE_BITS) ? PH_R_HIGH : PH_R_ACKHIGH;
            return 1'b0;
         end
         PH_R_ACKHIGH: begin
            scl_lvl = 1'b0;
            seq_phase = PH_R_ACKLOW;
            return 1'b0;
         end
         PH_R_ACKLOW: begin
            sda_lvl = 1'b1;
            rx_held = shifter;
            return 1'b1;
         end
         default: begin
            return 1'b1;
         end
      endcase
   endfunction

   function automatic rsp_word_type predict_bus_step(req_word_type w);
      rsp_word_type r;
      logic [7:0]   lim;
      bit           busy;
      bit           done;
      bit           rej;
      busy = (seq_phase != PH_IDLE);
      done = 1'b0;
      rej  = 1'b0;
      if (w.action == ACT_TICK) begin
         if (busy) begin
            lim = (half_ticks == 8'd0) ? 8'd1 : half_ticks;
            tick_cnt = tick_cnt + 8'd1;
            if (tick_cnt >= lim) begin
               tick_cnt = 8'd0;
               if (bus_half_step(w.sda_line)) begin
                  seq_phase = PH_IDLE;
                  done = 1'b1;
               end
            end
         end
      end else if (w.action <= ACT_READ) begin
         if (busy) begin
            rej = 1'b1;
         end else begin
            tick_cnt = 8'd0;
            bit_cnt  = 4'd0;
            case (w.action)
               ACT_START: begin
                  scl_lvl = 1'b1;
                  sda_lvl = 1'b1;
                  seq_phase = PH_START_A;
               end
               ACT_STOP: begin
                  sda_lvl = 1'b0;
                  seq_phase = PH_STOP_A;
               end
               ACT_WRITE: begin
                  shifter = w.tx_byte;
                  sda_lvl = w.tx_byte[7];
                  seq_phase = PH_W_SETUP;
               end
               default: begin
                  rd_opts = {w.msb_first, w.send_nack};
                  shifter = 8'd0;
                  sda_lvl = 1'b1;
                  scl_lvl = 1'b1;
                  seq_phase = PH_R_HIGH;
               end
            endcase
         end
      end
      r.scl_drive = scl_lvl;
      r.sda_drive = sda_lvl;
      r.busy_res  = (seq_phase != PH_IDLE);
      r.done_res  = done;
      r.status    = bus_status;
      r.rx_byte   = rx_held;
      r.rejected  = rej;
      return r;
   endfunction

   function automatic req_word_type make_word(logic [2:0] act, logic [7:0] tx, logic nack,
                                              logic msb, logic line);
      req_word_type w;
      w.action    = act;
      w.tx_byte   = tx;
      w.send_nack = nack;
      w.msb_first = msb;
      w.sda_line  = line;
      return w;
   endfunction

   function automatic void check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         mismatch_count++;
      end
   endfunction

   task automatic send_word(req_word_type w);
      bit counts;
      if (idle_on && $urandom_range(0, 7) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= w;
      do @(posedge clock); while (req_stall);
      counts = (w.action <= ACT_READ) && (w.action != ACT_TICK || seq_phase != PH_IDLE);
      expected_reports.push_back(predict_bus_step(w));
      if (counts) live_words++;
   endtask

   task automatic issue_command(logic [2:0] act, logic [7:0] tx, logic nack, logic msb);
      send_word(make_word(act, tx, nack, msb, 1'($urandom_range(0, 1))));
   endtask

   task automatic finish_sequence(line_mode_type mode, int noise_pct);
      logic         line;
      req_word_type w;
      while (seq_phase != PH_IDLE) begin
         if ($urandom_range(0, 99) < noise_pct) begin
            w = make_word(3'($urandom_range(ACT_START, ACT_SPARE_HI)),
                          8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
         end else begin
            case (mode)
               LINE_LOW:    line = 1'b0;
               LINE_HIGH:   line = 1'b1;
               LINE_RANDOM: line = 1'($urandom_range(0, 1));
               default: begin
                  case (seq_phase)
                     PH_START_C:   line = 1'b0;
                     PH_STOP_C:    line = 1'b1;
                     PH_W_ACKWAIT: line = ($urandom_range(0, 9) == 0);
                     default:      line = 1'($urandom_range(0, 1));
                  endcase
               end
            endcase
            w = make_word(ACT_TICK, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 1)), line);
         end
         send_word(w);
      end
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (expected_reports.size() != 0) @(posedge clock);
   endtask

   task automatic write_half_period(logic [7:0] ticks);
      drain_results();
      csr_valid <= 1'b1;
      csr_wdata <= ticks;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      half_ticks = ticks;
   endtask

   task automatic test_idle_words();
      send_word(make_word(ACT_TICK, 8'h00, 1'b0, 1'b0, 1'b0));
      send_word(make_word(ACT_TICK, 8'hFF, 1'b1, 1'b1, 1'b1));
      for (int a = ACT_SPARE_LO; a <= ACT_SPARE_HI; a++) begin
         send_word(make_word(3'(a), 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                             1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))));
      end
   endtask

   task automatic test_start_stop();
      issue_command(ACT_START, 8'h00, 1'b0, 1'b0);
      finish_sequence(LINE_LOW, 0);
      issue_command(ACT_STOP, 8'h00, 1'b0, 1'b0);
      finish_sequence(LINE_HIGH, 0);
      write_half_period(8'd1);
      issue_command(ACT_START, 8'hFF, 1'b1, 1'b1);
      finish_sequence(LINE_HIGH, 0);
      issue_command(ACT_STOP, 8'hFF, 1'b1, 1'b1);
      finish_sequence(LINE_LOW, 0);
   endtask

   task automatic test_write();
      issue_command(ACT_WRITE, 8'hFF, 1'b0, 1'b0);
      finish_sequence(LINE_HIGH, 0);
      issue_command(ACT_WRITE, 8'h00, 1'b1, 1'b1);
      finish_sequence(LINE_LOW, 0);
   endtask

   task automatic test_read();
      issue_command(ACT_READ, 8'h00, 1'b1, 1'b1);
      finish_sequence(LINE_HIGH, 0);
      issue_command(ACT_READ, 8'hFF, 1'b0, 1'b0);
      finish_sequence(LINE_RANDOM, 0);
      issue_command(ACT_READ, 8'h5A, 1'b0, 1'b1);
      finish_sequence(LINE_LOW, 0);
   endtask

   task automatic test_busy_reject();
      issue_command(ACT_WRITE, 8'hA5, 1'b0, 1'b0);
      for (int a = ACT_START; a <= ACT_READ; a++) begin
         issue_command(3'(a), 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                       1'($urandom_range(0, 1)));
      end
      finish_sequence(LINE_PROPER, 0);
   endtask

   task automatic test_half_period_extremes();
      write_half_period(8'd0);
      issue_command(ACT_START, 8'h00, 1'b0, 1'b0);
      finish_sequence(LINE_PROPER, 0);
      issue_command(ACT_STOP, 8'h00, 1'b0, 1'b0);
      finish_sequence(LINE_PROPER, 0);
      write_half_period(8'd255);
      issue_command(ACT_START, 8'h00, 1'b0, 1'b0);
      finish_sequence(LINE_PROPER, 0);
   endtask

   task automatic test_random_traffic(int target, bit idling_allowed);
      int            pick;
      int            nbytes;
      line_mode_type mode;
      logic [2:0]    act;
      live_words = 0;
      while (live_words < target) begin
         idle_on = idling_allowed && ($urandom_range(0, 3) != 0);
         mode    = ($urandom_range(0, 3) == 0) ? LINE_RANDOM : LINE_PROPER;
         pick    = $urandom_range(0, 99);
         if (pick < 12) begin
            act = $urandom_range(0, 1) ? ACT_TICK
                                       : 3'($urandom_range(ACT_SPARE_LO, ACT_SPARE_HI));
            send_word(make_word(act, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                                1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))));
         end else if (pick < 70) begin
            nbytes = $urandom_range(1, 3);
            issue_command(ACT_START, 8'($urandom_range(0, 255)), 1'b0, 1'b0);
            finish_sequence(mode, 4);
            repeat (nbytes) begin
               act = $urandom_range(0, 1) ? ACT_WRITE : ACT_READ;
               issue_command(act, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                             1'($urandom_range(0, 1)));
               finish_sequence(mode, 4);
            end
            issue_command(ACT_STOP, 8'($urandom_range(0, 255)), 1'b0, 1'b0);
            finish_sequence(mode, 4);
         end else begin
            issue_command(3'($urandom_range(ACT_START, ACT_READ)), 8'($urandom_range(0, 255)),
                          1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            finish_sequence(mode, 4);
         end
      end
   endtask

   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
         stall_left = $urandom_range(1, 5);
      end
      rsp_stall <= (stall_left > 0);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_reports.size() == 0) begin
            $error("result word with no expectation pending");
            mismatch_count++;
         end else begin
            want_rsp = expected_reports.pop_front();
            check_field("scl_drive", want_rsp.scl_drive, rsp_word.scl_drive);
            check_field("sda_drive", want_rsp.sda_drive, rsp_word.sda_drive);
            check_field("busy_res", want_rsp.busy_res, rsp_word.busy_res);
            check_field("done_res", want_rsp.done_res, rsp_word.done_res);
            check_field("status", want_rsp.status, rsp_word.status);
            check_field("rx_byte", want_rsp.rx_byte, rsp_word.rx_byte);
            check_field("rejected", want_rsp.rejected, rsp_word.rejected);
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_CYCLES) begin
         $display("i2c_byte_master: mismatch");
         $finish;
      end
   end

   initial begin
      repeat (3) @(posedge clock);
      reset   <= 1'b0;
      idle_on = 1'b1;
      test_idle_words();
      test_start_stop();
      test_write();
      test_read();
      test_busy_reject();
      test_half_period_extremes();
      write_half_period(8'd1);
      test_random_traffic(150, 1'b1);
      write_half_period(8'd3);
      test_random_traffic(150, 1'b1);
      write_half_period(8'($urandom_range(2, 4)));
      test_random_traffic(150, 1'b0);
      idle_on = 1'b0;
      drain_results();
      repeat (4) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("i2c_byte_master: match");
      end else begin
         $display("i2c_byte_master: mismatch");
      end
      $finish;
   end

endmodule

// ===== i2c_byte_master.f =====
+incdir+rtl
rtl/i2cbm_pkg.sv
rtl/i2cbm_seq.sv
rtl/i2cbm_out.sv
rtl/i2c_byte_master.sv
rtl/i2cbm_chk.sv
tb/tb_top.sv
